// ===== rtl/bank_switch_mapper_with_scanline_irq_defines.svh =====
// Assertion macros for the mapper. Each expects a clock named clk and an
// active-low reset named arst_n in the module that uses it.
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define BSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked during reset as well
`define BSM_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSM_ASSERT(lbl, prop, msg)
`define BSM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/bsm_pkg.sv =====
package bsm_pkg;

	localparam logic [2:0] FUNC_REG_WRITE = 3'd0;
	localparam logic [2:0] FUNC_TICK      = 3'd1;
	localparam logic [2:0] FUNC_CHR       = 3'd2;
	localparam logic [2:0] FUNC_PRG       = 3'd3;
	localparam logic [2:0] FUNC_RAM_RD    = 3'd4;
	localparam logic [2:0] FUNC_RAM_WR    = 3'd5;

	// register window, address bits 14:13 above 0x8000
	localparam logic [1:0] WIN_BANK   = 2'd0;
	localparam logic [1:0] WIN_MIRROR = 2'd1;
	localparam logic [1:0] WIN_IRQ    = 2'd2;
	localparam logic [1:0] WIN_IRQ_EN = 2'd3;

	localparam logic [7:0] PRG_UNITS_RESET = 8'd2;
	localparam logic [7:0] MASK_CHR_2K     = 8'hFE;
	localparam logic [7:0] MASK_PRG        = 8'h3F;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] address;
		logic [7:0]  data;
	} in_item_t;

	typedef struct packed {
		logic [21:0] rom_offset;
		logic        hit;
		logic        mirror_horizontal;
		logic        irq_request;
	} out_item_t;

endpackage

// ===== rtl/bank_switch_mapper_with_scanline_irq.sv =====
// Each accepted beat passes the input register, then the result register, before its
// result can be taken.
// Throughput: one beat per cycle; on a stall the skid register absorbs one beat, and
// req_ready drops once the skid and the input register are both full.
// req_ready depends on registers only, never combinationally on rsp_ready.
// Reset: all mapper state to its defaults, RAM enabled, program size 2, buffers empty.
`include "bank_switch_mapper_with_scanline_irq_defines.svh"

module bank_switch_mapper_with_scanline_irq
	import bsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  in_item_t   req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output out_item_t  rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      fire_s1;
	out_item_t result;
	logic      out_valid_q;
	logic      skid_valid_q;
	out_item_t out_q;
	out_item_t skid_q;
	logic      pop;

	assign req_ready = !valid_s1 || !skid_valid_q;
	assign fire_s1   = valid_s1 && !skid_valid_q;
	assign pop       = out_valid_q && rsp_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	bsm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			// advance skid to head, else take the new result
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= fire_s1;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= fire_s1;
		end else if (fire_s1) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if ((pop || !out_valid_q) && fire_s1) begin
			out_q <= result;
		end
		if (out_valid_q && !pop && fire_s1) begin
			skid_q <= result;
		end
	end

	`BSM_ASSERT(a_skid_needs_head, skid_valid_q |-> out_valid_q, "skid full, head empty")
	`BSM_ASSERT(a_stall_fills_skid, (out_valid_q && !rsp_ready && fire_s1) |=> skid_valid_q, "lost")
	`BSM_ASSERT(a_irq_only_tick, (fire_s1 && result.irq_request) |-> (item_s1.func == FUNC_TICK), "irq")
	`BSM_ASSERT_RST(a_reset_quiet, !arst_n |=> (!rsp_valid && !skid_valid_q), "pending in reset")

endmodule

// ===== rtl/bsm_core.sv =====
module bsm_core
	import bsm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	output out_item_t result
);

	logic [7:0] prg_units_q;
	logic [2:0] bank_target_q;
	logic       prg_swap_q;
	logic       chr_invert_q;
	logic [7:0] bank_regs_q [8];
	logic       mirror_q;
	logic       ram_enabled_q;
	logic       ram_locked_q;
	logic [7:0] irq_reload_q;
	logic [7:0] irq_counter_q;
	logic       irq_enabled_q;

	logic       is_reg_write;
	logic [1:0] reg_win;
	logic       odd;
	logic [7:0] bank_wdata;
	logic [7:0] counter_next;
	logic       mirror_next;

	assign is_reg_write = (item.func == FUNC_REG_WRITE) && item.address[15];
	assign reg_win      = item.address[14:13];
	assign odd          = item.address[0];
	assign counter_next = (irq_counter_q == 8'd0) ? irq_reload_q : irq_counter_q - 8'd1;
	assign mirror_next  = (is_reg_write && reg_win == WIN_MIRROR && !odd) ?
		item.data[0] : mirror_q;

	always_comb begin
		bank_wdata = item.data;
		if (bank_target_q <= 3'd1) begin
			bank_wdata = item.data & MASK_CHR_2K;
		end else if (bank_target_q >= 3'd6) begin
			bank_wdata = item.data & MASK_PRG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_units_q <= PRG_UNITS_RESET;
		end else if (cfg_we) begin
			prg_units_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_target_q <= '0;
			prg_swap_q    <= 1'b0;
			chr_invert_q  <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				bank_regs_q[i] <= '0;
			end
			mirror_q      <= 1'b0;
			ram_enabled_q <= 1'b1;
			ram_locked_q  <= 1'b0;
			irq_reload_q  <= '0;
			irq_counter_q <= '0;
			irq_enabled_q <= 1'b0;
		end else if (fire) begin
			mirror_q <= mirror_next;
			if (item.func == FUNC_TICK) begin
				irq_counter_q <= counter_next;
			end
			if (is_reg_write) begin
				case (reg_win)
					WIN_BANK: begin
						if (!odd) begin
							bank_target_q <= item.data[2:0];
							prg_swap_q    <= item.data[6];
							chr_invert_q  <= item.data[7];
						end else begin
							bank_regs_q[bank_target_q] <= bank_wdata;
						end
					end
					WIN_MIRROR: begin
						if (odd) begin
							ram_locked_q  <= item.data[6];
							ram_enabled_q <= item.data[7];
						end
					end
					WIN_IRQ: begin
						if (!odd) begin
							irq_reload_q <= item.data;
						end else begin
							irq_counter_q <= '0;
						end
					end
					WIN_IRQ_EN: begin
						irq_enabled_q <= odd;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// translation paths
	logic [2:0]  chr_win;
	logic [7:0]  chr_bank;
	logic [8:0]  chr_page;
	logic [7:0]  prg_last_pair;
	logic [8:0]  prg_page;

	always_comb begin
		chr_win = item.address[12:10] ^ {chr_invert_q, 2'b00};
		if (!chr_win[2]) begin
			chr_bank = bank_regs_q[{2'b00, chr_win[1]}];
			chr_page = {1'b0, chr_bank} + {8'd0, chr_win[0]};
		end else begin
			chr_bank = bank_regs_q[chr_win - 3'd2];
			chr_page = {1'b0, chr_bank};
		end
	end

	// the last two 8K banks sit at the end of ROM, wrapping for a size of zero
	assign prg_last_pair = prg_units_q - 8'd1;

	always_comb begin
		case (item.address[14:13])
			2'd0:    prg_page = prg_swap_q ? {prg_last_pair, 1'b0} : {1'b0, bank_regs_q[6]};
			2'd1:    prg_page = {1'b0, bank_regs_q[7]};
			2'd2:    prg_page = prg_swap_q ? {1'b0, bank_regs_q[6]} : {prg_last_pair, 1'b0};
			default: prg_page = {prg_last_pair, 1'b1};
		endcase
	end

	always_comb begin
		result = '0;
		result.mirror_horizontal = mirror_next;
		case (item.func)
			FUNC_REG_WRITE: begin
				result.hit = item.address[15];
			end
			FUNC_TICK: begin
				result.hit         = 1'b1;
				result.irq_request = (counter_next == 8'd0) && irq_enabled_q;
			end
			FUNC_CHR: begin
				if (item.address[15:13] == 3'b000) begin
					result.rom_offset = {3'b000, chr_page, item.address[9:0]};
					result.hit        = 1'b1;
				end
			end
			FUNC_PRG: begin
				if (item.address[15]) begin
					result.rom_offset = {prg_page, item.address[12:0]};
					result.hit        = 1'b1;
				end
			end
			FUNC_RAM_RD, FUNC_RAM_WR: begin
				if (item.address[15:13] == 3'b011) begin
					result.rom_offset = {9'd0, item.address[12:0]};
					result.hit = (item.func == FUNC_RAM_RD) ? ram_enabled_q :
						(ram_enabled_q && !ram_locked_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/bank_switch_mapper_with_scanline_irq_checker.sv =====
module bank_switch_mapper_with_scanline_irq_checker
	import bsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  in_item_t   req,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  out_item_t  rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output int         mismatches,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] rom_units;
	logic [2:0] bank_sel;
	logic       prg_swap;
	logic       chr_swap;
	logic [7:0] banks [8];
	logic       mirror_h;
	logic       ram_on;
	logic       ram_ro;
	logic [7:0] irq_latch;
	logic [7:0] irq_count;
	logic       irq_armed;
	out_item_t  pending_answers [$];

	initial mismatches = 0;

	function automatic void clear_mapper();
		rom_units = PRG_UNITS_RESET;
		bank_sel  = '0;
		prg_swap  = 1'b0;
		chr_swap  = 1'b0;
		foreach (banks[i]) banks[i] = '0;
		mirror_h  = 1'b0;
		ram_on    = 1'b1;
		ram_ro    = 1'b0;
		irq_latch = '0;
		irq_count = '0;
		irq_armed = 1'b0;
	endfunction

	// Apply one access to the mapper state and return the answer it should give.
	function automatic out_item_t map_access(input in_item_t a);
		out_item_t   r;
		logic [2:0]  win;
		logic [7:0]  v;
		logic [21:0] rom_end;
		logic [21:0] base;
		r = '0;
		case (a.func)
		FUNC_REG_WRITE: if (a.address[15]) begin
			r.hit = 1'b1;
			case (a.address[14:13])
			WIN_BANK: if (!a.address[0]) begin
				bank_sel = a.data[2:0];
				prg_swap = a.data[6];
				chr_swap = a.data[7];
			end else begin
				v = a.data;
				if (bank_sel <= 3'd1)
					v &= MASK_CHR_2K;
				else if (bank_sel >= 3'd6)
					v &= MASK_PRG;
				banks[bank_sel] = v;
			end
			WIN_MIRROR: if (!a.address[0]) begin
				mirror_h = a.data[0];
			end else begin
				ram_ro = a.data[6];
				ram_on = a.data[7];
			end
			WIN_IRQ: if (!a.address[0])
				irq_latch = a.data;
			else
				irq_count = '0;
			default: irq_armed = a.address[0];
			endcase
		end
		FUNC_TICK: begin
			if (irq_count == 8'd0)
				irq_count = irq_latch;
			else
				irq_count = irq_count - 8'd1;
			r.irq_request = (irq_count == 8'd0) && irq_armed;
			r.hit = 1'b1;
		end
		FUNC_CHR: if (a.address[15:13] == 3'b000) begin
			// inversion swaps the 2K and 1K halves of the pattern space
			win = a.address[12:10] ^ {chr_swap, 2'b00};
			if (!win[2])
				base = (22'(banks[{2'b00, win[1]}]) << 10) + (22'(win[0]) << 10);
			else
				base = 22'(banks[win - 3'd2]) << 10;
			r.rom_offset = base + 22'(a.address[9:0]);
			r.hit = 1'b1;
		end
		FUNC_PRG: if (a.address[15]) begin
			// fixed banks wrap inside the 22-bit space when the size is zero
			rom_end = 22'(rom_units) << 14;
			case (a.address[14:13])
			2'd0: base = prg_swap ? rom_end - 22'd16384 : 22'(banks[6]) << 13;
			2'd1: base = 22'(banks[7]) << 13;
			2'd2: base = prg_swap ? 22'(banks[6]) << 13 : rom_end - 22'd16384;
			default: base = rom_end - 22'd8192;
			endcase
			r.rom_offset = base + 22'(a.address[12:0]);
			r.hit = 1'b1;
		end
		FUNC_RAM_RD, FUNC_RAM_WR: if (a.address[15:13] == 3'b011) begin
			r.rom_offset = 22'(a.address[12:0]);
			r.hit = ram_on && (a.func == FUNC_RAM_RD || !ram_ro);
		end
		default: ;
		endcase
		r.mirror_horizontal = mirror_h;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mapper mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [21:0] want,
			input logic [21:0] got);
		if (want !== got)
			report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			clear_mapper();
			pending_answers.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				rom_units = cfg_wdata;
			if (rsp_valid && rsp_ready) begin
				if (pending_answers.size() == 0) begin
					report_mismatch($sformatf("unexpected beat offset %0h hit %0b",
						rsp.rom_offset, rsp.hit));
				end else begin
					want = pending_answers.pop_front();
					check_field("rom_offset", want.rom_offset, rsp.rom_offset);
					check_field("hit", 22'(want.hit), 22'(rsp.hit));
					check_field("mirror_horizontal", 22'(want.mirror_horizontal),
						22'(rsp.mirror_horizontal));
					check_field("irq_request", 22'(want.irq_request), 22'(rsp.irq_request));
				end
			end
			if (req_valid && req_ready)
				pending_answers.push_back(map_access(req));
			outstanding <= pending_answers.size();
		end
	end

endmodule

// ===== tb/bank_switch_mapper_with_scanline_irq_tb.sv =====
module bank_switch_mapper_with_scanline_irq_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_STALL     = 300;
	localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	in_item_t   req       = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	out_item_t  rsp;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = '0;

	int   send_idle   = 0;
	int   recv_idle   = 0;
	logic stall_go    = 1'b0;
	int   stall_left  = 0;
	int   idle_cycles = 0;
	int   beats_sent  = 0;
	int   mismatches;
	int   outstanding;

	always #5 clk = ~clk;

	bank_switch_mapper_with_scanline_irq uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	bank_switch_mapper_with_scanline_irq_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Result side: random back-pressure, or a long hold-off when asked.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_go) begin
			rsp_ready <= 1'b0;
			stall_left <= LONG_STALL;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_beat(input in_item_t item);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_rom_units(input logic [7:0] units);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= units;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly in-window accesses so the mapping and IRQ logic get exercised,
	// with a little noise on every code and address.
	function automatic in_item_t random_access();
		in_item_t a;
		int       pick;
		a.data = 8'($urandom);
		a.address = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 3) begin
			a.func = 3'($urandom);
		end else if (pick < 33) begin
			a.func = FUNC_REG_WRITE;
			a.address[15] = ($urandom_range(19) != 0);
			// keep the reload small so the counter hits zero often
			if (a.address[14:13] == WIN_IRQ && !a.address[0] && $urandom_range(3) != 0)
				a.data = 8'($urandom_range(4));
		end else if (pick < 53) begin
			a.func = FUNC_TICK;
		end else if (pick < 68) begin
			a.func = FUNC_CHR;
			if ($urandom_range(9) != 0)
				a.address[15:13] = 3'b000;
		end else if (pick < 83) begin
			a.func = FUNC_PRG;
			if ($urandom_range(9) != 0)
				a.address[15] = 1'b1;
		end else begin
			a.func = $urandom_range(1) ? FUNC_RAM_RD : FUNC_RAM_WR;
			if ($urandom_range(9) != 0)
				a.address[15:13] = 3'b011;
		end
		return a;
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_beat(random_access());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write below the register space, then the default program and character mappings
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'h7FFF, 8'hFF});
		send_beat(in_item_t'{FUNC_PRG, 16'h8000, 8'h00});
		send_beat(in_item_t'{FUNC_PRG, 16'hFFFF, 8'h00});
		send_beat(in_item_t'{FUNC_PRG, 16'h7FFF, 8'h00});
		send_beat(in_item_t'{FUNC_CHR, 16'h0000, 8'h00});
		send_beat(in_item_t'{FUNC_CHR, 16'h1FFF, 8'h00});
		send_beat(in_item_t'{FUNC_CHR, 16'h2000, 8'h00});
		// program swap with a masked bank 6, then character inversion
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'h8000, 8'hC6});
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'h8001, 8'hFF});
		send_beat(in_item_t'{FUNC_PRG, 16'h8000, 8'h00});
		send_beat(in_item_t'{FUNC_PRG, 16'hC000, 8'h00});
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'h8000, 8'h80});
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'h8001, 8'hFF});
		send_beat(in_item_t'{FUNC_CHR, 16'h1000, 8'h00});
		send_beat(in_item_t'{FUNC_CHR, 16'h1400, 8'h00});
		// mirroring and write-protected RAM
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'hA000, 8'h01});
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'hA001, 8'hC0});
		send_beat(in_item_t'{FUNC_RAM_RD, 16'h6000, 8'h00});
		send_beat(in_item_t'{FUNC_RAM_WR, 16'h7FFF, 8'h00});
		send_beat(in_item_t'{FUNC_RAM_RD, 16'h5FFF, 8'h00});
		send_beat(in_item_t'{FUNC_RAM_WR, 16'h8000, 8'h00});
		// reload, count down to an interrupt, clear, disable
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'hC000, 8'h01});
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'hE001, 8'h00});
		send_beat(in_item_t'{FUNC_TICK, 16'h0000, 8'h00});
		send_beat(in_item_t'{FUNC_TICK, 16'h0000, 8'h00});
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'hC001, 8'h00});
		send_beat(in_item_t'{FUNC_TICK, 16'h0000, 8'h00});
		send_beat(in_item_t'{FUNC_REG_WRITE, 16'hE000, 8'h00});
		send_beat(in_item_t'{FUNC_TICK, 16'hFFFF, 8'hFF});
		send_beat(in_item_t'{FUNC_SPARE_LO, 16'hFFFF, 8'hFF});
		send_beat(in_item_t'{FUNC_SPARE_HI, 16'h8001, 8'h3F});

		// zero-sized program ROM: fixed banks wrap to the top
		set_rom_units(8'd0);
		send_beat(in_item_t'{FUNC_PRG, 16'h8000, 8'h00});
		send_beat(in_item_t'{FUNC_PRG, 16'hC000, 8'h00});
		send_beat(in_item_t'{FUNC_PRG, 16'hE000, 8'h00});

		set_rom_units(8'd1);
		send_idle = 34;
		recv_idle <= 62;
		send_random(200);
		// hold the result side off while beats keep coming
		req_valid <= 1'b0;
		stall_go <= 1'b1;
		@(posedge clk);
		stall_go <= 1'b0;
		send_random(450);

		set_rom_units(8'd255);
		send_idle = 62;
		recv_idle <= 34;
		send_random(300);
		wait_drained();
		send_random(350);

		set_rom_units(8'($urandom_range(255, 1)));
		send_idle = 0;
		recv_idle <= 0;
		send_random(650);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d beats: directed corners, program ROM of 0, 1, 255 and random units,",
			beats_sent);
		$display("three idle mixes on both sides, a long result stall and a full mid-run drain.");
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bsm_pkg.sv
rtl/bsm_core.sv
rtl/bank_switch_mapper_with_scanline_irq.sv
tb/bank_switch_mapper_with_scanline_irq_checker.sv
tb/bank_switch_mapper_with_scanline_irq_tb.sv
